/* hw/rtl/kplc_pkg.sv */
package kplc_pkg;

   localparam int IdCount = 5;

   typedef enum logic [1:0] {
      STAT_ENTERING = 2'd0,
      STAT_GRANTED  = 2'd1,
      STAT_DENIED   = 2'd2,
      STAT_LOCKED   = 2'd3
   } status_type;

   localparam logic       CMD_KEY  = 1'b0;
   localparam logic       CMD_TICK = 1'b1;

   localparam logic [3:0] KEY_LAST_DIGIT = 4'd9;
   localparam logic [3:0] KEY_DELETE     = 4'd13;
   localparam logic [3:0] KEY_ENTER      = 4'd15;

   localparam logic [2:0] CSR_ID_ZERO    = 3'd0;
   localparam logic [2:0] CSR_ID_ONE     = 3'd1;
   localparam logic [2:0] CSR_ID_TWO     = 3'd2;
   localparam logic [2:0] CSR_ID_THREE   = 3'd3;
   localparam logic [2:0] CSR_ID_FOUR    = 3'd4;
   localparam logic [2:0] CSR_LOCKOUT_MS = 3'd5;
   localparam logic [2:0] CSR_FAIL_LIMIT = 3'd6;

   localparam logic [2:0] ENTRY_MAX = 3'd4;
   localparam logic [2:0] FAIL_MAX  = 3'd7;

   typedef logic [IdCount-1:0][15:0] id_set_type;

   localparam id_set_type ID_RESET = {16'h1122, 16'h0987, 16'h5432, 16'h6789, 16'h1234};
   localparam logic [15:0] LOCKOUT_RESET    = 16'd15000;
   localparam logic [2:0]  FAIL_LIMIT_RESET = 3'd3;

   // ceil(ms / 1000) = floor((ms + 999) * 134218 / 2**27) for ms below 2**17
   localparam logic [16:0] MS_ROUND_UP = 17'd999;
   localparam logic [17:0] SEC_RECIP   = 18'd134218;
   localparam int          SecShift    = 27;

   typedef struct packed {
      id_set_type  ids;
      logic [15:0] lockout_ms;
      logic [2:0]  fail_limit;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  user_index;
      logic [2:0]  entry_length;
      logic [16:0] rem_up;
      logic [2:0]  fail_total;
   } step_result_type;

endpackage

/* hw/rtl/kplc_core.sv */
module kplc_core import kplc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            item_valid,
   output logic            item_ready,
   input  logic            item_cmd,
   input  logic [3:0]      item_key,
   output logic            res_valid,
   input  logic            res_ready,
   output step_result_type res
);

   logic            locked_ff, locked_in;
   logic [15:0]     digits_ff, digits_in;
   logic [2:0]      count_ff, count_in;
   logic [2:0]      fails_ff, fails_in;
   logic [15:0]     elapsed_ff, elapsed_in;
   logic            res_valid_ff;
   step_result_type res_ff, res_in;

   logic            fire;
   logic            hit;
   logic [2:0]      hit_index;
   logic [15:0]     elapsed_inc;
   logic [2:0]      fails_inc;
   status_type      status_in;

   assign item_ready = !res_valid_ff || res_ready;
   assign fire       = item_valid && item_ready;
   assign res_valid  = res_valid_ff;
   assign res        = res_ff;

   always_comb begin
      hit       = 1'b0;
      hit_index = 3'd0;
      for (int i = IdCount - 1; i >= 0; i--) begin
         if (cfg.ids[i] == digits_ff) begin
            hit       = 1'b1;
            hit_index = 3'(i);
         end
      end
      if (count_ff != ENTRY_MAX) begin
         hit = 1'b0;
      end
   end

   assign elapsed_inc = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;
   assign fails_inc   = (fails_ff == FAIL_MAX) ? fails_ff : fails_ff + 3'd1;

   always_comb begin
      locked_in  = locked_ff;
      digits_in  = digits_ff;
      count_in   = count_ff;
      fails_in   = fails_ff;
      elapsed_in = elapsed_ff;
      status_in  = STAT_ENTERING;
      res_in     = '0;
      if (item_cmd == CMD_TICK) begin
         if (locked_ff) begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cfg.lockout_ms) begin
               locked_in = 1'b0;
               fails_in  = 3'd0;
               digits_in = 16'd0;
               count_in  = 3'd0;
            end
         end
      end else if (!locked_ff) begin
         if (item_key <= KEY_LAST_DIGIT) begin
            if (count_ff < ENTRY_MAX) begin
               digits_in = {digits_ff[11:0], item_key};
               count_in  = count_ff + 3'd1;
            end
         end else if (item_key == KEY_DELETE) begin
            if (count_ff != 3'd0) begin
               digits_in = {4'd0, digits_ff[15:4]};
               count_in  = count_ff - 3'd1;
            end
         end else if (item_key == KEY_ENTER) begin
            digits_in = 16'd0;
            count_in  = 3'd0;
            if (hit) begin
               fails_in          = 3'd0;
               status_in         = STAT_GRANTED;
               res_in.user_index = hit_index;
            end else begin
               fails_in = fails_inc;
               if (fails_inc >= cfg.fail_limit) begin
                  locked_in  = 1'b1;
                  elapsed_in = 16'd0;
               end else begin
                  status_in = STAT_DENIED;
               end
            end
         end
      end
      if (locked_in) begin
         status_in = STAT_LOCKED;
      end
      res_in.status       = status_in;
      res_in.entry_length = count_in;
      res_in.fail_total   = fails_in;
      if (locked_in && (elapsed_in < cfg.lockout_ms)) begin
         res_in.rem_up = {1'b0, cfg.lockout_ms - elapsed_in} + MS_ROUND_UP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff    <= 1'b0;
         digits_ff    <= 16'd0;
         count_ff     <= 3'd0;
         fails_ff     <= 3'd0;
         elapsed_ff   <= 16'd0;
         res_valid_ff <= 1'b0;
      end else begin
         if (fire) begin
            locked_ff  <= locked_in;
            digits_ff  <= digits_in;
            count_ff   <= count_in;
            fails_ff   <= fails_in;
            elapsed_ff <= elapsed_in;
         end
         if (fire) begin
            res_valid_ff <= 1'b1;
         end else if (res_ready) begin
            res_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         res_ff <= res_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ENTRY_MAX)
      else $error("entry count above four");

   a_locked_empty: assert property (@(posedge clock) disable iff (reset)
      locked_ff |-> (count_ff == 3'd0))
      else $error("digits held while locked");

   a_grant_clears: assert property (@(posedge clock) disable iff (reset)
      (res_valid_ff && res_ff.status == STAT_GRANTED) |-> (res_ff.fail_total == 3'd0))
      else $error("granted word with nonzero fail count");

endmodule

/* hw/rtl/kplc_out.sv */
module kplc_out import kplc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   output logic            res_ready,
   input  step_result_type res,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [15:0]     rsp_tdata,
   output logic [1:0]      rsp_tuser
);

   logic        valid_ff;
   logic [15:0] data_ff, data_in;
   logic [1:0]  user_ff;
   logic [34:0] product;
   logic [6:0]  seconds;
   logic        fire;

   assign res_ready  = !valid_ff || rsp_tready;
   assign fire       = res_valid && res_ready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   assign product = 35'(res.rem_up) * 35'(SEC_RECIP);
   assign seconds = product[SecShift +: 7];
   assign data_in = {res.fail_total, seconds, res.entry_length, res.user_index};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (fire) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= data_in;
         user_ff <= res.status;
      end
   end

   a_secs_locked: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff[12:6] != 7'd0) |-> (user_ff == STAT_LOCKED))
      else $error("seconds left while not locked");

   a_secs_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff[12:6] <= 7'd66))
      else $error("seconds left out of range");

endmodule

/* hw/rtl/keypad_pin_lock_controller_top.sv */
// Each request word passes the input, step and output registers in order.
// Throughput: one request word per cycle while rsp_tready is high; the
// step logic and the seconds divider (reciprocal multiply) are registered.
// Configuration writes are registered and csr_ready is always high.
// Synchronous active-high reset: lock open, entry empty, fail count zero,
// registers at their default IDs, 15000 ms lockout, limit of three.
module keypad_pin_lock_controller_top import kplc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // key_code[3:0], zero [7:4]
   input  logic        req_tuser,   // cmd[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // user_index[2:0], entry_length[5:3],
                                    // seconds_left[12:6], fail_total[15:13]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cfg_type         cfg_ff;
   logic            in_valid_ff;
   logic            in_cmd_ff;
   logic [3:0]      in_key_ff;
   logic            core_ready;
   logic            res_valid;
   logic            res_ready;
   step_result_type res;

   assign csr_ready  = 1'b1;
   assign req_tready = !in_valid_ff || core_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ids        <= ID_RESET;
         cfg_ff.lockout_ms <= LOCKOUT_RESET;
         cfg_ff.fail_limit <= FAIL_LIMIT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ID_ZERO:    cfg_ff.ids[0]     <= csr_data;
            CSR_ID_ONE:     cfg_ff.ids[1]     <= csr_data;
            CSR_ID_TWO:     cfg_ff.ids[2]     <= csr_data;
            CSR_ID_THREE:   cfg_ff.ids[3]     <= csr_data;
            CSR_ID_FOUR:    cfg_ff.ids[4]     <= csr_data;
            CSR_LOCKOUT_MS: cfg_ff.lockout_ms <= csr_data;
            CSR_FAIL_LIMIT: cfg_ff.fail_limit <= csr_data[2:0];
            default:        cfg_ff.fail_limit <= cfg_ff.fail_limit;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff <= req_tuser;
         in_key_ff <= req_tdata[3:0];
      end
   end

   kplc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (in_valid_ff),
      .item_ready (core_ready),
      .item_cmd   (in_cmd_ff),
      .item_key   (in_key_ff),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   kplc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
